// ===== hdl/rmps_pkg.sv =====
// -----------------------------------------------------------------------------
// rmps_pkg: shared types and constants
// Value and sum widths, saturation limit and the result record of the rhombus path sum.
// -----------------------------------------------------------------------------
package rmps_pkg;

	localparam int VAL_W = 8;
	localparam int SUM_W = 16;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	typedef struct packed {
		logic [SUM_W-1:0] best_sum;
		logic             saturated;
	} res_t;

	// write strobes toward the row store
	typedef struct packed {
		logic sum_en;   // write the cell sum at the cell column
		logic zero_en;  // write zero one column past the cell
	} wr_en_t;

endpackage

// ===== hdl/rhombus_max_path_sum.sv =====
// -----------------------------------------------------------------------------
// rhombus_max_path_sum: maximum path sum over a rhombus of numbers
// Cells arrive row by row; a row store keeps the best sum reaching each cell
// of the previous row. The cell that closes the shape yields the best sum.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+--------------------------------------
//  cell    | cell_valid   | cell_stall   | cell_value, row_widens, row_end,
//          |              |              | shape_end
//  result  | result_valid | result_stall | best_sum, saturated
//
// One cell per cycle while cell_stall is low. A cell reads the row store at
// its accept edge and writes back in the next cycle; the following cell
// takes the fresh sums through forwarding. A closing cell pushes its result from stage 1.
// Reset clears control state only; a fill count makes unwritten entries read
// as zero, so no clearing pass is needed after reset or between shapes.
// cell_stall rises when the result queue is full, or when it holds one result
// and a closing cell sits in stage 1.
// -----------------------------------------------------------------------------
module rhombus_max_path_sum #(
	parameter int MAX_ROW_WIDTH = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cell_valid,
	output logic                                cell_stall,
	input  logic [rmps_pkg::VAL_W-1:0]          cell_value,
	input  logic                                row_widens,
	input  logic                                row_end,
	input  logic                                shape_end,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [rmps_pkg::SUM_W-1:0]          best_sum,
	output logic                                saturated
);

	localparam int CW = $clog2(MAX_ROW_WIDTH + 2);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_ROW_WIDTH);
	localparam int SW = rmps_pkg::SUM_W;

	logic accept;

	// column and fill count, advanced at accept
	logic [CW-1:0] col_q, hw_q;
	logic [CW-1:0] col_n, hw_n, hw_t1, hw_t2, col_p1;

	// stage 1
	logic                       vld_s1;
	logic [CW-1:0]              col_s1;
	logic [rmps_pkg::VAL_W-1:0] value_s1;
	logic                       widens_s1, rowend_s1, shape_s1;
	logic                       za_s1, zb_s1;

	// write-back of the previous cell, for forwarding
	logic          wb_vld_q;
	logic [CW-1:0] wb_col_q;
	logic [SW-1:0] wb_sum_q;
	logic          wb_rowend_q;

	logic [SW-1:0] left_q, row0_q;
	logic          sat_q;

	logic [SW-1:0] rd_at, rd_next;
	logic [SW-1:0] above, next_sum, other, best;
	logic [SW:0]   sum_w;
	logic [SW-1:0] sum;
	logic          sat_now;
	logic [CW-1:0] col_s1_p1, wb_col_p1;

	rmps_pkg::wr_en_t wr_en;
	rmps_pkg::res_t   res;
	rmps_pkg::res_t   q_head;
	logic [1:0]       q_cnt;
	logic             push;

	assign cell_stall = (q_cnt == 2'd2) || ((q_cnt == 2'd1) && vld_s1 && shape_s1);
	assign accept     = cell_valid && !cell_stall;

	// next column and fill count
	always_comb begin
		col_p1 = col_q + CW'(1);
		if (shape_end || row_end)
			col_n = '0;
		else if (col_q < MAX_C)
			col_n = col_p1;
		else
			col_n = col_q;
		hw_t1 = (col_q < MAX_C) ? col_p1 : hw_q;
		hw_t2 = (row_end && (col_p1 < MAX_C)) ? (col_q + CW'(2)) : hw_t1;
		if (shape_end)
			hw_n = '0;
		else
			hw_n = (hw_t2 > hw_q) ? hw_t2 : hw_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			hw_q   <= '0;
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			if (accept) begin
				col_q <= col_n;
				hw_q  <= hw_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1    <= col_q;
			value_s1  <= cell_value;
			widens_s1 <= row_widens;
			rowend_s1 <= row_end;
			shape_s1  <= shape_end;
			// entries at or past the fill count read as zero
			za_s1     <= (col_q >= hw_q);
			zb_s1     <= (col_p1 >= hw_q);
		end
	end

	rmps_row_store #(
		.MAX_ROW_WIDTH(MAX_ROW_WIDTH),
		.CW           (CW)
	) u_store (
		.clk    (clk),
		.rd_col (col_q),
		.wr_col (col_s1),
		.wr_sum (sum),
		.wr_en  (wr_en),
		.rd_at  (rd_at),
		.rd_next(rd_next)
	);

	// stage 1: forward, pick the larger parent, add, clamp
	always_comb begin
		col_s1_p1 = col_s1 + CW'(1);
		wb_col_p1 = wb_col_q + CW'(1);

		if (za_s1)
			above = '0;
		else if (wb_vld_q && (wb_col_q == col_s1))
			above = wb_sum_q;
		else if (wb_vld_q && wb_rowend_q && (wb_col_p1 == col_s1))
			above = '0;
		else
			above = rd_at;

		if (zb_s1)
			next_sum = '0;
		else if (wb_vld_q && (wb_col_q == col_s1_p1))
			next_sum = wb_sum_q;
		else if (wb_vld_q && wb_rowend_q && (wb_col_p1 == col_s1_p1))
			next_sum = '0;
		else
			next_sum = rd_next;

		if (widens_s1)
			other = (col_s1 != '0) ? left_q : '0;
		else
			other = next_sum;

		best    = (above > other) ? above : other;
		sum_w   = {1'b0, best} + {{(SW + 1 - rmps_pkg::VAL_W){1'b0}}, value_s1};
		sat_now = sum_w[SW];
		sum     = sat_now ? rmps_pkg::SUM_MAX : sum_w[SW-1:0];

		wr_en.sum_en  = vld_s1 && (col_s1 < MAX_C);
		wr_en.zero_en = vld_s1 && rowend_s1 && (col_s1_p1 < MAX_C);

		push          = vld_s1 && shape_s1;
		res.best_sum  = (col_s1 == '0) ? sum : row0_q;
		res.saturated = sat_q || sat_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_vld_q <= 1'b0;
			left_q   <= '0;
			row0_q   <= '0;
			sat_q    <= 1'b0;
		end else begin
			wb_vld_q <= vld_s1;
			if (vld_s1) begin
				if (shape_s1) begin
					left_q <= '0;
					row0_q <= '0;
					sat_q  <= 1'b0;
				end else begin
					left_q <= above;
					sat_q  <= sat_q || sat_now;
					if (col_s1 == '0)
						row0_q <= sum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		wb_col_q    <= col_s1;
		wb_sum_q    <= sum;
		wb_rowend_q <= rowend_s1;
	end

	rmps_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(res),
		.stall    (result_stall),
		.valid    (result_valid),
		.head     (q_head),
		.count    (q_cnt)
	);

	assign best_sum  = q_head.best_sum;
	assign saturated = q_head.saturated;

endmodule

// ===== hdl/rmps_row_store.sv =====
// -----------------------------------------------------------------------------
// rmps_row_store: best sums of the previous row
// Two banks split by column parity, so the cell column and the one after it
// are read, and written, in the same cycle. Read data is registered.
// -----------------------------------------------------------------------------
module rmps_row_store #(
	parameter int MAX_ROW_WIDTH = 64,
	parameter int CW            = 7
) (
	input  logic                        clk,
	input  logic [CW-1:0]               rd_col,
	input  logic [CW-1:0]               wr_col,
	input  logic [rmps_pkg::SUM_W-1:0]  wr_sum,
	input  rmps_pkg::wr_en_t            wr_en,
	output logic [rmps_pkg::SUM_W-1:0]  rd_at,
	output logic [rmps_pkg::SUM_W-1:0]  rd_next
);

	localparam int BD  = (MAX_ROW_WIDTH + 1) / 2;
	localparam int BAW = (BD > 1) ? $clog2(BD) : 1;

	logic [rmps_pkg::SUM_W-1:0] mem_e [BD];
	logic [rmps_pkg::SUM_W-1:0] mem_o [BD];
	logic [rmps_pkg::SUM_W-1:0] rd_e_q, rd_o_q;
	logic                       par_q;

	logic [CW-1:0]  rd_col_p1, wr_col_p1;
	logic [CW-1:0]  ra_e, ra_o, wa_e, wa_o;
	logic [BAW-1:0] ri_e, ri_o, wi_e, wi_o;
	logic           we_e, we_o;
	logic [rmps_pkg::SUM_W-1:0] wd_e, wd_o;

	function automatic logic [BAW-1:0] bank_idx(input logic [CW-1:0] a);
		logic [CW-2:0] ie;
		ie = a[CW-1:1];
		if (int'(ie) < BD)
			return ie[BAW-1:0];
		return '0;
	endfunction

	assign rd_col_p1 = rd_col + CW'(1);
	assign wr_col_p1 = wr_col + CW'(1);

	always_comb begin
		ra_e = rd_col[0] ? rd_col_p1 : rd_col;
		ra_o = rd_col[0] ? rd_col : rd_col_p1;
		ri_e = bank_idx(ra_e);
		ri_o = bank_idx(ra_o);
		// the sum goes to the bank of its own parity, the zero to the other one
		if (wr_col[0]) begin
			wa_o = wr_col;
			wd_o = wr_sum;
			we_o = wr_en.sum_en;
			wa_e = wr_col_p1;
			wd_e = '0;
			we_e = wr_en.zero_en;
		end else begin
			wa_e = wr_col;
			wd_e = wr_sum;
			we_e = wr_en.sum_en;
			wa_o = wr_col_p1;
			wd_o = '0;
			we_o = wr_en.zero_en;
		end
		wi_e = bank_idx(wa_e);
		wi_o = bank_idx(wa_o);
	end

	always_ff @(posedge clk) begin
		if (we_e)
			mem_e[wi_e] <= wd_e;
		rd_e_q <= mem_e[ri_e];
	end

	always_ff @(posedge clk) begin
		if (we_o)
			mem_o[wi_o] <= wd_o;
		rd_o_q <= mem_o[ri_o];
	end

	always_ff @(posedge clk) begin
		par_q <= rd_col[0];
	end

	assign rd_at   = par_q ? rd_o_q : rd_e_q;
	assign rd_next = par_q ? rd_e_q : rd_o_q;

endmodule

// ===== hdl/rmps_out_queue.sv =====
// -----------------------------------------------------------------------------
// rmps_out_queue: two-entry result queue
// Holds finished results while the output side stalls.
// -----------------------------------------------------------------------------
module rmps_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rmps_pkg::res_t   push_data,
	input  logic             stall,
	output logic             valid,
	output rmps_pkg::res_t   head,
	output logic [1:0]       count
);

	rmps_pkg::res_t head_q, tail_q;
	logic [1:0]     cnt_q;
	logic           pop;

	assign valid = (cnt_q != 2'd0);
	assign pop   = valid && !stall;
	assign head  = head_q;
	assign count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0)
					head_q <= push_data;
				else
					tail_q <= push_data;
			end
			2'b01: begin
				head_q <= tail_q;
			end
			2'b11: begin
				if (cnt_q == 2'd1) begin
					head_q <= push_data;
				end else begin
					head_q <= tail_q;
					tail_q <= push_data;
				end
			end
			default: begin
				head_q <= head_q;
			end
		endcase
	end

endmodule

// ===== hdl/rmps_checker.sv =====
// -----------------------------------------------------------------------------
// rmps_checker: port-level checks of the rhombus path sum block
// Watches both channels and ties results to closing cells.
// -----------------------------------------------------------------------------
module rmps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cell_valid,
	input logic        cell_stall,
	input logic        shape_end,
	input logic        result_valid,
	input logic        result_stall,
	input logic [15:0] best_sum,
	input logic        saturated
);

	// a stalled result transaction holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(best_sum)
			&& $stable(saturated))
		else $error("result changed while stalled");

	// a closing cell is followed by a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && !cell_stall && shape_end |-> ##2 result_valid)
		else $error("closing cell gave no result");

	// a result appears only after a closing cell
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cell_valid && !cell_stall && shape_end, 2))
		else $error("result without a closing cell");

endmodule

bind rhombus_max_path_sum rmps_checker u_rmps_checker (.*);

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// testbench: self-checking bench for rhombus_max_path_sum
// Streams well-formed rhombi, ragged shapes and loose cells into the block with
// random gaps on both channels. A scoreboard predicts every best path sum and
// compares each result transaction against the oldest prediction.
// -----------------------------------------------------------------------------
module testbench;

	localparam int ROW_W       = 64;
	localparam int CELL_TARGET = 1700;
	localparam int IDLE_LIMIT  = 4000;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cell_valid = 1'b0;
	logic                       cell_stall;
	logic [rmps_pkg::VAL_W-1:0] cell_value = '0;
	logic                       row_widens = 1'b0;
	logic                       row_end = 1'b0;
	logic                       shape_end = 1'b0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic [rmps_pkg::SUM_W-1:0] best_sum;
	logic                       saturated;

	bit quiet = 1'b0;
	int cells_sent = 0;
	int idle_cycles = 0;

	// predicts the best path sum of each shape from the accepted cells
	class path_sum_tracker;
		logic [rmps_pkg::SUM_W-1:0] row_best[ROW_W];
		logic [rmps_pkg::SUM_W-1:0] left_best;
		int unsigned                col;
		bit                         clamp_seen;
		rmps_pkg::res_t             expected_sums[$];
		int                         errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			foreach (row_best[i])
				row_best[i] = '0;
			left_best = '0;
			col = 0;
			clamp_seen = 1'b0;
		endfunction

		function logic [rmps_pkg::SUM_W-1:0] read_best(int unsigned idx);
			return (idx < ROW_W) ? row_best[idx] : '0;
		endfunction

		function void note_cell(logic [rmps_pkg::VAL_W-1:0] v, logic widens,
				logic last_in_row, logic last_in_shape);
			logic [rmps_pkg::SUM_W-1:0] above;
			logic [rmps_pkg::SUM_W-1:0] other;
			int unsigned                total;
			rmps_pkg::res_t             res;
			above = read_best(col);
			if (widens)
				other = (col > 0) ? left_best : '0;
			else
				other = read_best(col + 1);
			total = ((above > other) ? above : other) + v;
			if (total > rmps_pkg::SUM_MAX) begin
				total = rmps_pkg::SUM_MAX;
				clamp_seen = 1'b1;
			end
			left_best = above;
			if (col < ROW_W)
				row_best[col] = total[rmps_pkg::SUM_W-1:0];
			if (last_in_row) begin
				if (col + 1 < ROW_W)
					row_best[col + 1] = '0;
				col = 0;
			end else if (col < ROW_W) begin
				col++;
			end
			if (last_in_shape) begin
				res.best_sum = row_best[0];
				res.saturated = clamp_seen;
				expected_sums = {expected_sums, res};
				clear();
			end
		endfunction

		function void check_result(logic [rmps_pkg::SUM_W-1:0] got_sum, logic got_sat);
			rmps_pkg::res_t exp_res;
			if (expected_sums.size() == 0) begin
				$display("%0t: unexpected result: best_sum %0d saturated %0b",
					$time, got_sum, got_sat);
				errors++;
				return;
			end
			exp_res = expected_sums.pop_front();
			if (got_sum !== exp_res.best_sum) begin
				$display("%0t: best_sum mismatch: expected %0d, actual %0d",
					$time, exp_res.best_sum, got_sum);
				errors++;
			end
			if (got_sat !== exp_res.saturated) begin
				$display("%0t: saturated mismatch: expected %0b, actual %0b",
					$time, exp_res.saturated, got_sat);
				errors++;
			end
		endfunction
	endclass

	path_sum_tracker tracker = new();

	rhombus_max_path_sum #(
		.MAX_ROW_WIDTH(ROW_W)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cell_valid(cell_valid),
		.cell_stall(cell_stall),
		.cell_value(cell_value),
		.row_widens(row_widens),
		.row_end(row_end),
		.shape_end(shape_end),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.best_sum(best_sum),
		.saturated(saturated)
	);

	always #6 clk = ~clk;

	// mostly short gaps, a few long ones, none at all in quiet stretches
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// call at a falling edge; returns at the falling edge after acceptance
	task automatic send_cell(input logic [rmps_pkg::VAL_W-1:0] v, input logic widens,
			input logic last_in_row, input logic last_in_shape);
		int gap;
		bit taken;
		gap = pick_gap();
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cell_value <= v;
		row_widens <= widens;
		row_end <= last_in_row;
		shape_end <= last_in_shape;
		cell_valid <= 1'b1;
		taken = 1'b0;
		while (!taken) begin
			@(posedge clk);
			taken = !cell_stall;
		end
		tracker.note_cell(v, widens, last_in_row, last_in_shape);
		cells_sent++;
		@(negedge clk);
	endtask

	// rows of the given lengths; direction follows the lengths unless random_dir
	task automatic send_shape(input int lens[$], input int vlo, input int vhi,
			input bit random_dir);
		logic widens;
		for (int r = 0; r < lens.size(); r++) begin
			if (random_dir || r == 0)
				widens = 1'($urandom_range(0, 1));
			else
				widens = lens[r] > lens[r - 1];
			for (int c = 0; c < lens[r]; c++)
				send_cell(8'($urandom_range(vhi, vlo)), widens, c == lens[r] - 1,
					r == lens.size() - 1 && c == lens[r] - 1);
		end
	endtask

	task automatic send_rhombus(input int width, input int vlo, input int vhi);
		int rows[$];
		for (int i = 1; i <= width; i++)
			rows = {rows, i};
		for (int i = width - 1; i >= 1; i--)
			rows = {rows, i};
		send_shape(rows, vlo, vhi, 1'b0);
	endtask

	// result side back-pressure
	initial begin
		forever begin
			int g;
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 20)) @(negedge clk);
			g = pick_gap();
			if (g > 0) begin
				result_stall <= 1'b1;
				repeat (g) @(negedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_result(best_sum, saturated);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cell_valid && !cell_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		int rows[$];
		int r;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-cell shapes, with and without row_end
		send_cell(8'd255, 1'b1, 1'b1, 1'b1);
		send_cell(8'd0, 1'b0, 1'b0, 1'b1);
		// small rhombus at the value extremes
		send_cell(8'd0, 1'b1, 1'b1, 1'b0);
		send_cell(8'd255, 1'b1, 1'b0, 1'b0);
		send_cell(8'd1, 1'b1, 1'b1, 1'b0);
		send_cell(8'd128, 1'b0, 1'b1, 1'b1);
		rows = {1, 2, 3, 2, 1};
		send_shape(rows, 255, 255, 1'b0);
		// shape closed in the middle of a row
		send_cell(8'd7, 1'b1, 1'b1, 1'b0);
		send_cell(8'd9, 1'b1, 1'b0, 1'b0);
		send_cell(8'd200, 1'b1, 1'b0, 1'b1);
		// ragged rows read stale entries
		rows = {4, 1, 2};
		send_shape(rows, 0, 255, 1'b1);

		// tall one-cell columns drive the sums into saturation
		rows.delete();
		repeat (265) rows = {rows, 1};
		send_shape(rows, 250, 255, 1'b0);
		send_shape(rows, 250, 255, 1'b1);
		// rows longer than the store
		rows = {70, 66, 3, 1};
		send_shape(rows, 0, 255, 1'b1);

		while (cells_sent < CELL_TARGET) begin
			quiet = ($urandom_range(0, 5) == 0);
			r = $urandom_range(0, 99);
			if (r < 65) begin
				if ($urandom_range(0, 4) == 0)
					send_rhombus($urandom_range(7, 12), 0, 255);
				else if ($urandom_range(0, 5) == 0)
					send_rhombus($urandom_range(1, 6), 200, 255);
				else
					send_rhombus($urandom_range(1, 6), 0, 255);
			end else if (r < 82) begin
				rows.delete();
				repeat ($urandom_range(1, 6))
					rows = {rows,
						int'($urandom_range(1, ($urandom_range(0, 15) == 0) ? 70 : 8))};
				send_shape(rows, 0, 255, 1'($urandom_range(0, 1)));
			end else begin
				// loose cells with arbitrary flags
				repeat ($urandom_range(1, 10))
					send_cell(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0);
			end
		end
		quiet = 1'b0;
		cell_valid <= 1'b0;

		while (tracker.expected_sums.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
